/* rtl/rc_ppm_pulse_decoder_unit_macros.svh */
// ----------------------------------------------------------------------------
// RC PPM pulse decoder assertion macros
// Shared property wrappers for the decoder's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RC_PPM_PULSE_DECODER_UNIT_MACROS_SVH
`define RC_PPM_PULSE_DECODER_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define RPPD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define RPPD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rppd_pkg.sv */
// ----------------------------------------------------------------------------
// RC PPM pulse decoder package
// Types and constants shared by the decoder's modules.
// ----------------------------------------------------------------------------
package rppd_pkg;

   localparam int SLOT_W    = 6;   // signed slot, -1 .. 31
   localparam int STAMP_W   = 16;
   localparam int INDEX_W   = 4;
   localparam int VALUE_W   = 8;
   localparam int CSR_IDX_W = 2;

   localparam logic [SLOT_W-1:0] SLOT_RESTART = '1;          // minus one
   localparam logic [SLOT_W-1:0] SLOT_FIRST   = '0;
   localparam logic [SLOT_W-1:0] SLOT_MAX     = SLOT_W'(31);
   localparam logic [SLOT_W-1:0] SLOT_CHECK   = SLOT_W'(5);
   localparam logic [SLOT_W-1:0] SLOT_GOOD    = SLOT_W'(7);

   localparam logic [STAMP_W-1:0] WIDTH_HI_MASK = 16'hff00;
   localparam logic [STAMP_W-1:0] WIDTH_HI_TAG  = 16'h0100;
   localparam logic [STAMP_W-1:0] WIDTH_LO_MASK = 16'h00ff;

   typedef enum logic {
      MODE_EDGE    = 1'b0,
      MODE_TIMEOUT = 1'b1
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COMBINED_TRAIN = 2'd0,
      CSR_START_POLARITY = 2'd1
   } csr_index_type;

   typedef struct packed {
      mode_type             mode;
      logic [STAMP_W-1:0]   timestamp;
   } item_type;

   typedef struct packed {
      logic combined_train;
      logic start_polarity;
   } cfg_type;

   typedef struct packed {
      logic [SLOT_W-1:0]  slot_index;
      logic [STAMP_W-1:0] previous_edge;
      logic               frame_valid;
      logic               new_values;
      logic               signal_good;
      logic               first_timeout_seen;
      logic               edge_select;
      logic               long_period;
      logic [STAMP_W-1:0] bad_frames;
   } state_type;

   typedef struct packed {
      logic               channel_write;
      logic [INDEX_W-1:0] channel_index;
      logic [VALUE_W-1:0] channel_value;
      logic               frame_ready;
      logic               signal_present;
      logic [STAMP_W-1:0] bad_frame_count;
      logic               capture_rising;
      logic               long_timeout;
   } result_type;

endpackage

/* rtl/rppd_in_stage.sv */
// ----------------------------------------------------------------------------
// RC PPM pulse decoder input register
// Holds one accepted request until the decode stage takes it.
// ----------------------------------------------------------------------------
module rppd_in_stage
   import rppd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  item_type req_item,
   input  logic     advance,
   output logic     item_valid,
   output item_type item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     accept;

   assign req_ready = !valid_ff || advance;
   assign accept    = req_valid && req_ready;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= req_item;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

/* rtl/rppd_core.sv */
// ----------------------------------------------------------------------------
// RC PPM pulse decoder core
// Frame state, per-event update and the result register.
// ----------------------------------------------------------------------------
module rppd_core
   import rppd_pkg::*;
#(
   parameter int CHANNEL_SLOTS = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       item_valid,
   input  item_type   item,
   output logic       advance,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       fire;

   logic [STAMP_W-1:0] width;
   logic               slot_neg;
   logic               slot_ge_check;
   logic               slot_ge_good;
   logic               in_range;
   logic               restart;
   logic               good;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign fire    = item_valid && advance;

   assign width         = (item.timestamp - state_ff.previous_edge) >> 1;
   assign slot_neg      = state_ff.slot_index[SLOT_W-1];
   assign slot_ge_check = !slot_neg && (state_ff.slot_index >= SLOT_CHECK);
   assign slot_ge_good  = !slot_neg && (state_ff.slot_index >= SLOT_GOOD);
   assign in_range      = !slot_neg &&
                          (32'(state_ff.slot_index[SLOT_W-2:0]) < CHANNEL_SLOTS);

   always_comb begin
      state_in = state_ff;
      restart  = 1'b0;
      good     = 1'b0;
      rsp_in   = '0;

      if (item.mode == MODE_EDGE) begin
         state_in.first_timeout_seen = 1'b0;
         if (!cfg.combined_train) begin
            state_in.edge_select = !state_ff.edge_select;
            state_in.long_period = 1'b0;
         end
         state_in.previous_edge = item.timestamp;
         if (state_ff.slot_index == SLOT_FIRST) begin
            state_in.frame_valid = 1'b1;
         end else begin
            if ((width & WIDTH_HI_MASK) != WIDTH_HI_TAG) begin
               state_in.frame_valid = 1'b0;
            end
            if (in_range) begin
               rsp_in.channel_write = 1'b1;
               rsp_in.channel_index = state_ff.slot_index[INDEX_W-1:0];
               rsp_in.channel_value = VALUE_W'(width & WIDTH_LO_MASK);
            end
         end

         // combined train checks every slot from 5 on, separate pulses only at 5
         if (cfg.combined_train) begin
            if (slot_ge_check) begin
               if (state_in.frame_valid) begin
                  good = slot_ge_good;
               end else begin
                  restart = 1'b1;
               end
            end
         end else if (state_ff.slot_index == SLOT_CHECK) begin
            good    = state_in.frame_valid;
            restart = !state_in.frame_valid;
         end

         if (good) begin
            state_in.new_values  = 1'b1;
            state_in.signal_good = 1'b1;
         end

         if (restart) begin
            state_in.slot_index = SLOT_FIRST;   // back to the first slot (zero), then counted up
         end else if (state_ff.slot_index != SLOT_MAX) begin
            state_in.slot_index = state_ff.slot_index + SLOT_W'(1);
         end
      end else begin
         if (!cfg.combined_train) begin
            restart                     = state_ff.first_timeout_seen;
            state_in.first_timeout_seen = 1'b1;
            state_in.long_period        = 1'b1;
         end
         state_in.slot_index = SLOT_FIRST;
      end

      if (restart) begin
         state_in.bad_frames  = state_ff.bad_frames + STAMP_W'(1);
         state_in.new_values  = 1'b0;
         state_in.signal_good = 1'b0;
         if (!cfg.combined_train) begin
            state_in.edge_select = cfg.start_polarity;
         end
      end

      rsp_in.frame_ready     = state_in.new_values;
      rsp_in.signal_present  = state_in.signal_good;
      rsp_in.bad_frame_count = state_in.bad_frames;
      rsp_in.capture_rising  = state_in.edge_select;
      rsp_in.long_timeout    = state_in.long_period;
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.slot_index         <= SLOT_RESTART;
         state_ff.previous_edge      <= '0;
         state_ff.frame_valid        <= 1'b0;
         state_ff.new_values         <= 1'b0;
         state_ff.signal_good        <= 1'b0;
         state_ff.first_timeout_seen <= 1'b0;
         state_ff.edge_select        <= 1'b0;
         state_ff.long_period        <= 1'b0;
         state_ff.bad_frames         <= '0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         if (fire) begin
            state_ff <= state_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

/* rtl/rc_ppm_pulse_decoder_unit.sv */
// ----------------------------------------------------------------------------
// RC PPM pulse decoder unit
// Turns capture and timeout events into channel writes and frame status.
// ----------------------------------------------------------------------------
// Throughput: one request per clock while the result register is empty or
// being taken. A request is held in the input register, then registered
// into the result register, where it waits until the receiver takes it.
// Reset (synchronous, active high) empties both registers, sets the slot
// count to minus one and restores the configuration register defaults.
module rc_ppm_pulse_decoder_unit
   import rppd_pkg::*;
#(
   parameter int CHANNEL_SLOTS = 16
)
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [15:0]          req_tdata,   // timestamp[15:0]
   input  logic                 req_tuser,   // mode
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // channel_index[3:0], channel_value[11:4], frame_ready[12],
   // signal_present[13], bad_frame_count[29:14], capture_rising[30],
   // long_timeout[31]
   output logic [31:0]          rsp_tdata,
   output logic                 rsp_tuser,   // channel_write
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic                 csr_data
);

`include "rc_ppm_pulse_decoder_unit_macros.svh"

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   item_type   req_item;
   item_type   item;
   logic       item_valid;
   logic       advance;
   result_type rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_COMBINED_TRAIN: cfg_in.combined_train = csr_data;
            CSR_START_POLARITY: cfg_in.start_polarity = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.combined_train <= 1'b1;
         cfg_ff.start_polarity <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_item.mode      = mode_type'(req_tuser);
   assign req_item.timestamp = req_tdata;

   rppd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   rppd_core #(
      .CHANNEL_SLOTS (CHANNEL_SLOTS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item),
      .advance    (advance),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.channel_write;
   assign rsp_tdata = {rsp.long_timeout, rsp.capture_rising, rsp.bad_frame_count,
                       rsp.signal_present, rsp.frame_ready, rsp.channel_value,
                       rsp.channel_index};

   `RPPD_ASSERT_NEXT(a_item_to_result, clock, reset, item_valid && advance,
                     rsp_tvalid, "held request did not reach the result register")
   `RPPD_ASSERT_NOW(a_stall_only_on_full, clock, reset, !req_tready,
                    rsp_tvalid && !rsp_tready, "input stalled with output free")
   `RPPD_ASSERT_NOW(a_no_write_clean, clock, reset, rsp_tvalid && !rsp_tuser,
                    rsp_tdata[11:0] == 12'd0, "channel fields set without a write")

endmodule
